@@ hw/rtl/wwoc_pkg.sv @@
package wwoc_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_KEY_LENGTH  = 3'd0;
    localparam logic [2:0] REG_KEY_BYTES_0 = 3'd1;
    localparam logic [2:0] REG_KEY_BYTES_1 = 3'd2;
    localparam logic [2:0] REG_KEY_BYTES_2 = 3'd3;
    localparam logic [2:0] REG_KEY_BYTES_3 = 3'd4;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 64;
    localparam int KEY_LEN_BITS   = 6;
    localparam int KEY_WORDS      = 4;
    localparam int KEY_FLAT_BITS  = KEY_WORDS * CFG_DATA_BITS;

    // Front-to-back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;
    localparam int QCNT_BITS   = 3;

    // Word character ranges
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;

    // Classified byte as queued between front and back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_word;
        logic       last_byte;
    } item_t;

    function automatic logic is_word_char(input logic [7:0] b);
        return ((b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z)) ||
               ((b >= CHAR_LOWER_A) && (b <= CHAR_LOWER_Z)) ||
               ((b >= CHAR_DIGIT_0) && (b <= CHAR_DIGIT_9));
    endfunction

endpackage

@@ hw/rtl/wwoc_front.sv @@
module wwoc_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,
    input  logic               s_last_byte,
    output logic               q_valid,
    input  logic               q_pop,
    output wwoc_pkg::item_t    q_item
);

    wwoc_pkg::item_t                    slot_reg [wwoc_pkg::QUEUE_DEPTH];
    logic [wwoc_pkg::QPTR_BITS-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [wwoc_pkg::QPTR_BITS-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [wwoc_pkg::QCNT_BITS-1:0]     cnt_reg, cnt_next;
    wwoc_pkg::item_t                    in_item;
    logic                               push;
    logic                               pop;

    assign s_ready = (cnt_reg != wwoc_pkg::QCNT_BITS'(wwoc_pkg::QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != '0);
    assign pop     = q_pop && q_valid;
    assign q_item  = slot_reg[rd_ptr_reg];

    // classify on the way in
    always_comb begin
        in_item.data_byte = s_data_byte;
        in_item.is_word   = wwoc_pkg::is_word_char(s_data_byte);
        in_item.last_byte = s_last_byte;
    end

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ hw/rtl/wwoc_back.sv @@
module wwoc_back #(
    parameter int MAX_KEY_BYTES = 32,
    parameter int COUNT_BITS    = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [wwoc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [wwoc_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    input  logic                                  q_valid,
    output logic                                  q_pop,
    input  wwoc_pkg::item_t                       q_item,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [15:0]                           m_match_count
);

    localparam logic [1:0] MODE_CAND     = 2'd0;
    localparam logic [1:0] MODE_AFTER    = 2'd1;
    localparam logic [1:0] MODE_SKIPWORD = 2'd2;
    localparam logic [1:0] MODE_SKIPSEP  = 2'd3;
    localparam int         LB            = wwoc_pkg::KEY_LEN_BITS;
    localparam int         EXT_BITS      = COUNT_BITS + 16;

    logic [LB-1:0]                          key_length_reg;
    logic [wwoc_pkg::CFG_DATA_BITS-1:0]     key_reg [wwoc_pkg::KEY_WORDS];
    logic [wwoc_pkg::KEY_FLAT_BITS-1:0]     key_flat;

    logic [1:0]             mode_reg, mode_next;
    logic [LB-1:0]          pos_reg, pos_next;
    logic [COUNT_BITS-1:0]  total_reg, total_next;
    logic                   m_valid_reg, m_valid_next;
    logic [COUNT_BITS-1:0]  m_count_reg;
    logic [EXT_BITS-1:0]    count_ext;

    logic [LB-1:0]          eff_len;
    logic [LB-1:0]          pos_cmp;
    logic [LB-1:0]          pos_inc;
    logic [7:0]             key_byte;
    logic                   bump;
    logic                   do_compare;
    logic                   do_after;

    // key bytes and length; the user writes them only while idle, the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_length_reg <= LB'(1);
            for (int i = 0; i < wwoc_pkg::KEY_WORDS; i++) begin
                key_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            case (cfg_index)
                wwoc_pkg::REG_KEY_LENGTH:  key_length_reg <= cfg_wdata[LB-1:0];
                wwoc_pkg::REG_KEY_BYTES_0: key_reg[0] <= cfg_wdata;
                wwoc_pkg::REG_KEY_BYTES_1: key_reg[1] <= cfg_wdata;
                wwoc_pkg::REG_KEY_BYTES_2: key_reg[2] <= cfg_wdata;
                wwoc_pkg::REG_KEY_BYTES_3: key_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign key_flat = {key_reg[3], key_reg[2], key_reg[1], key_reg[0]};

    // zero length acts as one, long lengths clamp
    always_comb begin
        if (key_length_reg == '0) begin
            eff_len = LB'(1);
        end else if (key_length_reg > LB'(MAX_KEY_BYTES)) begin
            eff_len = LB'(MAX_KEY_BYTES);
        end else begin
            eff_len = key_length_reg;
        end
    end

    // a word start out of separators restarts the key at byte 0
    assign pos_cmp  = (mode_reg == MODE_SKIPSEP) ? '0 : pos_reg;
    assign pos_inc  = pos_cmp + 1'b1;
    assign key_byte = key_flat[pos_cmp[4:0]*8 +: 8];

    // results wait in the output register; non-last bytes never stall
    assign q_pop = q_valid && (!q_item.last_byte || !m_valid_reg || m_ready);

    always_comb begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        bump       = 1'b0;
        do_compare = 1'b0;
        do_after   = 1'b0;

        unique case (mode_reg)
            MODE_CAND:     do_compare = 1'b1;
            MODE_AFTER:    do_after   = 1'b1;
            MODE_SKIPWORD: begin
                if (!q_item.is_word) begin
                    mode_next = MODE_SKIPSEP;
                end
            end
            MODE_SKIPSEP: begin
                if (q_item.is_word) begin
                    do_compare = 1'b1;
                end
            end
        endcase

        // key shortened below the matched count: key counts as complete
        if (do_compare && (pos_cmp >= eff_len)) begin
            do_compare = 1'b0;
            do_after   = 1'b1;
        end

        if (do_after) begin
            bump      = !q_item.is_word;
            mode_next = q_item.is_word ? MODE_SKIPWORD : MODE_SKIPSEP;
            pos_next  = '0;
        end else if (do_compare) begin
            if (q_item.data_byte == key_byte) begin
                pos_next = pos_inc;
                if (pos_inc >= eff_len) begin
                    mode_next = MODE_AFTER;
                    bump      = q_item.last_byte;
                end else begin
                    mode_next = MODE_CAND;
                end
            end else begin
                mode_next = q_item.is_word ? MODE_SKIPWORD : MODE_SKIPSEP;
                pos_next  = '0;
            end
        end

        total_next = total_reg;
        if (bump && (total_reg != '1)) begin
            total_next = total_reg + 1'b1;
        end
    end

    assign m_valid_next = (q_pop && q_item.last_byte) || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_CAND;
            pos_reg     <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (q_pop) begin
                if (q_item.last_byte) begin
                    mode_reg  <= MODE_CAND;
                    pos_reg   <= '0;
                    total_reg <= '0;
                end else begin
                    mode_reg  <= mode_next;
                    pos_reg   <= pos_next;
                    total_reg <= total_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_item.last_byte) begin
            m_count_reg <= total_next;
        end
    end

    assign count_ext     = EXT_BITS'(m_count_reg);
    assign m_valid       = m_valid_reg;
    assign m_match_count = count_ext[15:0];

endmodule

@@ hw/rtl/whole_word_occurrence_counter.sv @@
// Whole-word keyword counter. Text bytes stream in on the s_ channel, one
// transaction per byte, with s_last_byte marking the final byte of a buffer.
// The block counts how often the configured keyword occurs as a whole word
// (only ASCII letters and digits are word characters) and, for each last
// byte, returns one m_ transaction carrying the count, saturated at
// 2^COUNT_BITS - 1; bytes that are not last produce nothing. Throughput is
// one byte per clock: the front classifies each byte and places it in a
// four-entry queue, the back runs the scan state machine at one queue entry
// per cycle. A count is raised on m_ at the clock edge where the back takes
// its last byte from the queue. Only a held result blocks the back on the
// next last byte. Write the keyword through cfg_wr_en / cfg_index /
// cfg_wdata only while the block is idle: index 0 is the key length
// (1..MAX_KEY_BYTES, 0 acts as 1), indexes 1..4 hold key bytes 0..31 with
// the lowest byte in the low bits. After each last byte the scan state and
// count restart; the key is kept.
module whole_word_occurrence_counter #(
    parameter int MAX_KEY_BYTES = 32,
    parameter int COUNT_BITS    = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [wwoc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [wwoc_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,

    // text byte stream
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [7:0]                           s_data_byte,
    input  logic                                 s_last_byte,

    // per-buffer count
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [15:0]                          m_match_count
);

    // queue between front and back
    logic               q_valid;
    logic               q_pop;
    wwoc_pkg::item_t    q_item;

    // front: classify bytes, buffer them
    wwoc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_item      (q_item)
    );

    // back: key match state machine, counter, result register
    wwoc_back #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES),
        .COUNT_BITS    (COUNT_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_item        (q_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_match_count (m_match_count)
    );

endmodule

@@ test/word_count_checker.sv @@
`timescale 1ns / 100ps

// Watches the config port and both channels, keeps its own model of the
// scan, and compares each returned count against the oldest predicted one.
module word_count_checker #(
    parameter int MAX_KEY_BYTES = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [wwoc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [wwoc_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic [7:0]                           s_data_byte,
    input  logic                                 s_last_byte,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic [15:0]                          m_match_count,
    output int                                   count_failures,
    output int                                   counts_pending,
    output int                                   counts_checked
);

    typedef enum logic [1:0] {
        SCAN_CANDIDATE,
        SCAN_AFTER_KEY,
        SCAN_SKIP_WORD,
        SCAN_SKIP_SEP
    } scan_state_t;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    logic [wwoc_pkg::KEY_LEN_BITS-1:0]  key_len_reg;
    logic [wwoc_pkg::CFG_DATA_BITS-1:0] key_word [wwoc_pkg::KEY_WORDS];
    scan_state_t                        scan_state;
    logic [5:0]                         matched_len;
    logic [15:0]                        running_count;
    logic [15:0]                        predicted_counts [$];
    logic [15:0]                        want;
    int                                 mismatch_total;
    int                                 checked_total;

    function automatic bit is_alnum(input logic [7:0] b);
        return ((b >= wwoc_pkg::CHAR_UPPER_A) && (b <= wwoc_pkg::CHAR_UPPER_Z)) ||
               ((b >= wwoc_pkg::CHAR_LOWER_A) && (b <= wwoc_pkg::CHAR_LOWER_Z)) ||
               ((b >= wwoc_pkg::CHAR_DIGIT_0) && (b <= wwoc_pkg::CHAR_DIGIT_9));
    endfunction

    // length 0 acts as 1, anything above the maximum is clipped
    function automatic int active_key_len();
        int n;
        n = int'(key_len_reg);
        if (n == 0) n = 1;
        if (n > MAX_KEY_BYTES) n = MAX_KEY_BYTES;
        return n;
    endfunction

    function automatic logic [7:0] key_char(input int pos);
        int p;
        p = pos % 32;
        return key_word[p / 8][(p % 8) * 8 +: 8];
    endfunction

    task automatic bump_count();
        if (running_count != COUNT_MAX) running_count = running_count + 1'b1;
    endtask

    task automatic skip_from(input logic [7:0] b);
        if (is_alnum(b)) scan_state = SCAN_SKIP_WORD;
        else scan_state = SCAN_SKIP_SEP;
        matched_len = '0;
    endtask

    // byte right after a complete key
    task automatic finish_key(input logic [7:0] b);
        if (!is_alnum(b)) bump_count();
        skip_from(b);
    endtask

    task automatic match_step(input logic [7:0] b, input logic last);
        int n;
        n = active_key_len();
        if (int'(matched_len) >= n) begin
            finish_key(b);
        end else if (b == key_char(int'(matched_len))) begin
            matched_len = matched_len + 1'b1;
            if (int'(matched_len) >= n) begin
                scan_state = SCAN_AFTER_KEY;
                if (last) bump_count();
            end else begin
                scan_state = SCAN_CANDIDATE;
            end
        end else begin
            skip_from(b);
        end
    endtask

    task automatic scan_text_byte(input logic [7:0] b, input logic last);
        case (scan_state)
            SCAN_CANDIDATE: match_step(b, last);
            SCAN_AFTER_KEY: finish_key(b);
            SCAN_SKIP_WORD: begin
                if (!is_alnum(b)) scan_state = SCAN_SKIP_SEP;
            end
            default: begin
                if (is_alnum(b)) begin
                    matched_len = '0;
                    match_step(b, last);
                end
            end
        endcase
        if (last) begin
            predicted_counts = {predicted_counts, running_count};
            scan_state    = SCAN_CANDIDATE;
            matched_len   = '0;
            running_count = '0;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            key_len_reg   = wwoc_pkg::KEY_LEN_BITS'(1);
            for (int w = 0; w < wwoc_pkg::KEY_WORDS; w++) key_word[w] = '0;
            scan_state    = SCAN_CANDIDATE;
            matched_len   = '0;
            running_count = '0;
            predicted_counts.delete();
            mismatch_total = 0;
            checked_total  = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    wwoc_pkg::REG_KEY_LENGTH:
                        key_len_reg = cfg_wdata[wwoc_pkg::KEY_LEN_BITS-1:0];
                    wwoc_pkg::REG_KEY_BYTES_0: key_word[0] = cfg_wdata;
                    wwoc_pkg::REG_KEY_BYTES_1: key_word[1] = cfg_wdata;
                    wwoc_pkg::REG_KEY_BYTES_2: key_word[2] = cfg_wdata;
                    wwoc_pkg::REG_KEY_BYTES_3: key_word[3] = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) scan_text_byte(s_data_byte, s_last_byte);
            if (m_valid && m_ready) begin
                if (predicted_counts.size() == 0) begin
                    $error("match_count: no count expected, actual %0d", m_match_count);
                    mismatch_total++;
                end else begin
                    want = predicted_counts.pop_front();
                    checked_total++;
                    if (m_match_count !== want) begin
                        $error("match_count mismatch: expected %0d, actual %0d",
                               want, m_match_count);
                        mismatch_total++;
                    end
                end
            end
        end
        count_failures <= mismatch_total;
        counts_pending <= predicted_counts.size();
        counts_checked <= checked_total;
    end

endmodule

@@ test/whole_word_occurrence_counter_tb.sv @@
`timescale 1ns / 100ps

module whole_word_occurrence_counter_tb;

    // Index beyond the register map; the block must ignore writes to it.
    localparam logic [wwoc_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;

    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // Cycles with no transaction at all before the run is declared hung.
    // The slowest correct gap is a sender gap plus a receiver stall plus the
    // pipeline and the settle pause; IDLE_LIMIT lies well above that.
    localparam int IDLE_LIMIT     = 200;
    localparam int SETTLE_CYCLES  = 4;
    localparam int PHASE_BYTES    = 60;
    localparam int RANDOM_PHASES  = 9;

    typedef enum int {
        KEY_ALNUM,
        KEY_MIXED,
        KEY_ALL_ONES
    } key_style_t;

    logic                                 aclk      = 1'b0;
    logic                                 aresetn   = 1'b0;
    logic                                 cfg_wr_en = 1'b0;
    logic [wwoc_pkg::CFG_INDEX_BITS-1:0]  cfg_index = '0;
    logic [wwoc_pkg::CFG_DATA_BITS-1:0]   cfg_wdata = '0;
    logic                                 s_valid   = 1'b0;
    logic                                 s_ready;
    logic [7:0]                           s_data_byte = '0;
    logic                                 s_last_byte = 1'b0;
    logic                                 m_valid;
    logic                                 m_ready   = 1'b0;
    logic [15:0]                          m_match_count;

    int count_failures;
    int counts_pending;
    int counts_checked;

    // Stimulus-side copy of the keyword, used to program the block and to build text that hits it.
    logic [7:0] key_text [32];
    int         key_span = 1;
    int         key_settings = 1;

    logic [7:0] text_buf [$];
    int         bytes_sent   = 0;
    int         buffers_sent = 0;
    bit         sender_steady   = 1'b0;
    bit         receiver_steady = 1'b0;
    int         ready_hold = 0;
    int         next_hold;
    int         idle_cycles = 0;
    int         phase;
    int         phase_start;

    whole_word_occurrence_counter DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_match_count (m_match_count)
    );

    word_count_checker count_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_match_count  (m_match_count),
        .count_failures (count_failures),
        .counts_pending (counts_pending),
        .counts_checked (counts_checked)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side: after each count transaction, hold ready low for a randomly drawn
    // stall (possibly none), unless this phase runs the receiver without stalls.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_hold <= 0;
        end else if (m_valid && m_ready) begin
            next_hold   = receiver_steady ? 0 : $urandom_range(0, 9);
            ready_hold <= next_hold;
            m_ready    <= (next_hold == 0);
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready    <= (ready_hold == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: any transaction or config write resets the idle counter.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [7:0] pick_word_char();
        int r;
        r = $urandom_range(0, 61);
        if (r < 26) return wwoc_pkg::CHAR_UPPER_A + 8'(r);
        if (r < 52) return wwoc_pkg::CHAR_LOWER_A + 8'(r - 26);
        return wwoc_pkg::CHAR_DIGIT_0 + 8'(r - 52);
    endfunction

    // Spaces half the time, otherwise any byte outside the word classes.
    function automatic logic [7:0] pick_separator();
        logic [7:0] b;
        if ($urandom_range(0, 1) == 0) return CHAR_SPACE;
        do b = 8'($urandom_range(0, 255)); while (wwoc_pkg::is_word_char(b));
        return b;
    endfunction

    task automatic append_byte(input logic [7:0] b);
        text_buf = {text_buf, b};
    endtask

    // One byte transaction. Called in the time step after the previous
    // acceptance (or after reset), so valid is only lowered when a gap is
    // actually drawn; back-to-back bytes keep valid high.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
        if (last) buffers_sent++;
    endtask

    task automatic flush_text();
        for (int i = 0; i < text_buf.size(); i++) begin
            send_byte(text_buf[i], i == text_buf.size() - 1);
        end
        text_buf.delete();
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++) append_byte(s[i]);
        flush_text();
    endtask

    // Stop sending and hold off until every predicted count has come back.
    // The first edge lets the checker's pending count catch up.
    task automatic wait_for_counts();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (counts_pending != 0) @(posedge aclk);
    endtask

    task automatic push_key_bytes(input int count);
        for (int i = 0; i < count; i++) append_byte(key_text[i]);
    endtask

    // Config writes: length (with junk in the upper bits), all four key words,
    // then one write to an unmapped index. One NBA per signal per step.
    task automatic program_key(input logic [wwoc_pkg::KEY_LEN_BITS-1:0] len_field);
        logic [wwoc_pkg::CFG_DATA_BITS-1:0] w;
        cfg_wr_en <= 1'b1;
        cfg_index <= wwoc_pkg::REG_KEY_LENGTH;
        cfg_wdata <= ({$urandom, $urandom} & ~64'h3F) | 64'(len_field);
        @(posedge aclk);
        for (int k = 0; k < wwoc_pkg::KEY_WORDS; k++) begin
            for (int j = 0; j < 8; j++) w[j*8 +: 8] = key_text[k*8 + j];
            cfg_index <= wwoc_pkg::REG_KEY_BYTES_0 + wwoc_pkg::CFG_INDEX_BITS'(k);
            cfg_wdata <= w;
            @(posedge aclk);
        end
        cfg_index <= REG_UNUSED;
        cfg_wdata <= {$urandom, $urandom};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        key_settings++;
        key_span = (len_field == 0) ? 1 : (int'(len_field) > 32 ? 32 : int'(len_field));
    endtask

    // Drain, let the pipeline go quiet, then load a fresh keyword.
    task automatic retune_key(input logic [wwoc_pkg::KEY_LEN_BITS-1:0] len_field,
                              input key_style_t style);
        wait_for_counts();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        for (int i = 0; i < 32; i++) begin
            case (style)
                KEY_ALNUM:    key_text[i] = pick_word_char();
                KEY_ALL_ONES: key_text[i] = 8'hFF;
                default: begin
                    // first byte stays a word char so word starts can match
                    if (i == 0 || $urandom_range(0, 3) != 0) key_text[i] = pick_word_char();
                    else key_text[i] = 8'($urandom_range(0, 255));
                end
            endcase
        end
        program_key(len_field);
    endtask

    // Mostly well-formed text built around the keyword: whole matches,
    // near misses, and matches glued to neighboring word chars. A slice of
    // buffers is raw noise.
    task automatic send_text_buffer();
        int tokens;
        if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 24)) append_byte(8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 1) == 1) begin
                repeat ($urandom_range(1, 2)) append_byte(pick_separator());
            end
            tokens = $urandom_range(1, 6);
            for (int k = 0; k < tokens; k++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: push_key_bytes(key_span);
                    4: begin
                        // key followed by a word char: not a whole word
                        push_key_bytes(key_span);
                        repeat ($urandom_range(1, 3)) append_byte(pick_word_char());
                    end
                    5: begin
                        // truncated key; at the buffer end this ends inside the key
                        push_key_bytes($urandom_range(0, key_span - 1));
                        if ($urandom_range(0, 1) == 1) append_byte(pick_word_char());
                    end
                    6: begin
                        // key inside a longer word: no word start at the key
                        append_byte(pick_word_char());
                        push_key_bytes(key_span);
                    end
                    7: repeat ($urandom_range(1, 6)) append_byte(pick_word_char());
                    8: begin
                        push_key_bytes(key_span);
                        text_buf[text_buf.size() - 1 - $urandom_range(0, key_span - 1)] =
                            8'($urandom_range(0, 255));
                    end
                    default: begin
                        push_key_bytes(key_span);
                        append_byte(8'($urandom_range(0, 255)));
                    end
                endcase
                if (k != tokens - 1 || $urandom_range(0, 1) == 1) begin
                    repeat ($urandom_range(0, 3)) append_byte(pick_separator());
                end
            end
        end
        flush_text();
    endtask

    // Single-byte key 'A' against the edges of every character class, a key
    // glued to word chars, a one-byte buffer, and the byte extremes.
    task automatic run_directed();
        wait_for_counts();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        key_text[0] = wwoc_pkg::CHAR_UPPER_A;
        for (int i = 1; i < 32; i++) key_text[i] = 8'h00;
        program_key(wwoc_pkg::KEY_LEN_BITS'(1));
        send_string("A@A[A`A{A/A:A");
        send_string("AZ Aa A0A9");
        send_string("A");
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    initial begin
        for (int i = 0; i < 32; i++) key_text[i] = 8'h00;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Phase 0 runs on the reset keyword (length 1, byte 0x00), then the
        // directed set, then a spread of key settings including length 0,
        // a length past the maximum, and keys made of non-word bytes.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                1: begin
                    run_directed();
                    retune_key(wwoc_pkg::KEY_LEN_BITS'(1), KEY_ALNUM);
                end
                2: retune_key(wwoc_pkg::KEY_LEN_BITS'(3), KEY_ALNUM);
                3: retune_key(wwoc_pkg::KEY_LEN_BITS'(0), KEY_ALNUM);
                4: retune_key(wwoc_pkg::KEY_LEN_BITS'(32), KEY_ALNUM);
                5: retune_key(wwoc_pkg::KEY_LEN_BITS'(63), KEY_MIXED);
                6: retune_key(wwoc_pkg::KEY_LEN_BITS'(5), KEY_MIXED);
                7: retune_key(wwoc_pkg::KEY_LEN_BITS'(8), KEY_ALL_ONES);
                8: retune_key(wwoc_pkg::KEY_LEN_BITS'(2), KEY_ALNUM);
                default: ;
            endcase
            sender_steady   = ($urandom_range(0, 3) == 0);
            receiver_steady = ($urandom_range(0, 3) == 0);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                send_text_buffer();
                // now and then, starve the block until all counts are back
                if ($urandom_range(0, 5) == 0) wait_for_counts();
            end
        end

        wait_for_counts();
        repeat (8) @(posedge aclk);

        $display("Run covered %0d bytes in %0d buffers over %0d key settings,", bytes_sent,
                 buffers_sent, key_settings);
        $display("including length 0, 63 and all-ones keys; %0d counts compared.",
                 counts_checked);
        if (count_failures == 0 && counts_pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
